### sv/assert_macros.svh
// assertion macros shared by the parser rtl
// used by the files that check their own logic, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on the rising clock, off while reset is low
`define FDTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define FDTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fdtp_pkg.sv
// shared types, constants and helpers of the framed decimal triplet parser
// no dependencies
package fdtp_pkg;

  localparam int unsigned VALUE_BITS  = 16;
  localparam int unsigned MAX_PAYLOAD = 127;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ACC_W       = VALUE_BITS + 1;
  localparam int unsigned MUL_W       = ACC_W + 3;
  localparam int unsigned FIDX_W      = 2;

  localparam logic [ACC_W-1:0]      MAG_LIMIT = ACC_W'(1) << (VALUE_BITS - 1);
  localparam logic [VALUE_BITS-1:0] POS_MAX   = VALUE_BITS'(MAG_LIMIT - 1'b1);
  localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_PAYLOAD);

  // configuration register indexes
  localparam logic CFG_OPEN  = 1'b0;
  localparam logic CFG_CLOSE = 1'b1;

  localparam logic [7:0] OPEN_RST  = 8'd60;
  localparam logic [7:0] CLOSE_RST = 8'd62;

  // parse phase codes
  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t [NUM_CHAN-1:0] chan;
    logic [FIDX_W-1:0]     fields;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

endpackage

### sv/fdtp_in_reg.sv
// input register holding one received byte request
// depends on nothing but the clock and reset
module fdtp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = valid_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### sv/fdtp_parse_core.sv
// frame tracking, on-the-fly decimal field parsing and channel hold state
// depends on fdtp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fdtp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  input  logic              advance_i,
  input  logic [7:0]        open_byte_i,
  input  logic [7:0]        close_byte_i,
  output logic              emit_o,
  output fdtp_pkg::result_t result_o
);

  localparam int unsigned NC = fdtp_pkg::NUM_CHAN;
  localparam int unsigned VB = fdtp_pkg::VALUE_BITS;
  localparam int unsigned AW = fdtp_pkg::ACC_W;
  localparam int unsigned MW = fdtp_pkg::MUL_W;

  logic                           in_frame_q, in_frame_d;
  logic [fdtp_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [fdtp_pkg::FIDX_W-1:0]    fidx_q, fidx_d;
  logic [1:0]                     phase_q, phase_d;
  logic                           neg_q, neg_d;
  logic [AW-1:0]                  acc_q, acc_d;
  logic [NC-1:0]                  mask_q, mask_d;
  fdtp_pkg::value_t [NC-1:0]      staged_q, staged_d;
  fdtp_pkg::value_t [NC-1:0]      held_q, held_d;

  logic                           is_close;
  logic                           is_dig;
  logic                           do_commit;
  logic                           restart;
  logic [AW-1:0]                  dval;
  logic [MW-1:0]                  prod;
  logic [AW-1:0]                  acc_sat;
  logic [AW-1:0]                  acc_neg;
  fdtp_pkg::value_t               cval;

  assign is_close = in_frame_q && (byte_i == close_byte_i);
  assign emit_o   = byte_valid_i && is_close;
  assign is_dig   = fdtp_pkg::is_digit(byte_i);

  // acc * 10 + digit, clamped to the magnitude limit
  assign dval    = {{(AW-4){1'b0}}, byte_i[3:0]};
  assign prod    = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1) + {3'b000, dval};
  assign acc_sat = (prod > {3'b000, fdtp_pkg::MAG_LIMIT}) ? fdtp_pkg::MAG_LIMIT : prod[AW-1:0];
  assign acc_neg = AW'(0) - acc_q;
  assign cval    = neg_q ? acc_neg[VB-1:0] :
                   ((acc_q > {1'b0, fdtp_pkg::POS_MAX}) ? fdtp_pkg::POS_MAX : acc_q[VB-1:0]);

  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    fidx_d     = fidx_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    mask_d     = mask_q;
    staged_d   = staged_q;
    held_d     = held_q;
    do_commit  = 1'b0;
    restart    = 1'b0;

    if (!in_frame_q) begin
      if (byte_i == open_byte_i) begin
        in_frame_d = 1'b1;
        cnt_d      = '0;
        fidx_d     = '0;
        phase_d    = fdtp_pkg::PH_SKIP;
        neg_d      = 1'b0;
        acc_d      = '0;
        mask_d     = '0;
      end
    end else if (is_close) begin
      do_commit  = (phase_q == fdtp_pkg::PH_DIGIT);
      in_frame_d = 1'b0;
    end else if (cnt_q < fdtp_pkg::CNT_MAX) begin
      cnt_d = cnt_q + 1'b1;
      if ((phase_q != fdtp_pkg::PH_STOP) && (fidx_q != 2'd3)) begin
        if (byte_i == fdtp_pkg::CH_NUL) begin
          // string end: finish a pending field and stop
          do_commit = (phase_q == fdtp_pkg::PH_DIGIT);
          phase_d   = fdtp_pkg::PH_STOP;
        end else begin
          case (phase_q)
            fdtp_pkg::PH_SKIP: restart = 1'b1;
            fdtp_pkg::PH_SIGN: begin
              if (is_dig) begin
                acc_d   = dval;
                phase_d = fdtp_pkg::PH_DIGIT;
              end else begin
                phase_d = fdtp_pkg::PH_STOP;
              end
            end
            default: begin
              if (is_dig) begin
                acc_d = acc_sat;
              end else begin
                // a non-digit ends this field and may open the next one
                do_commit = 1'b1;
                restart   = (fidx_q != 2'd2);
              end
            end
          endcase
        end
      end
    end else begin
      in_frame_d = 1'b0;
      cnt_d      = '0;
    end

    if (do_commit) begin
      for (int i = 0; i < NC; i++) begin
        if (fidx_q == fdtp_pkg::FIDX_W'(i)) begin
          staged_d[i] = cval;
          mask_d[i]   = 1'b1;
        end
      end
      fidx_d  = fidx_q + 1'b1;
      neg_d   = 1'b0;
      acc_d   = '0;
      phase_d = ((fidx_q == 2'd2) || (byte_i == fdtp_pkg::CH_NUL)) ?
                fdtp_pkg::PH_STOP : fdtp_pkg::PH_SKIP;
    end

    if (restart) begin
      if (fdtp_pkg::is_space(byte_i)) begin
        phase_d = fdtp_pkg::PH_SKIP;
      end else if ((byte_i == fdtp_pkg::CH_PLUS) || (byte_i == fdtp_pkg::CH_MINUS)) begin
        neg_d   = (byte_i == fdtp_pkg::CH_MINUS);
        phase_d = fdtp_pkg::PH_SIGN;
      end else if (is_dig) begin
        acc_d   = dval;
        phase_d = fdtp_pkg::PH_DIGIT;
      end else begin
        phase_d = fdtp_pkg::PH_STOP;
      end
    end

    if (is_close) begin
      for (int i = 0; i < NC; i++) begin
        if (mask_d[i]) begin
          held_d[i] = staged_d[i];
        end
      end
    end
  end

  assign result_o.chan   = held_d;
  assign result_o.fields = fidx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      fidx_q     <= '0;
      phase_q    <= fdtp_pkg::PH_SKIP;
      neg_q      <= 1'b0;
      acc_q      <= '0;
      mask_q     <= '0;
      staged_q   <= '0;
      held_q     <= '0;
    end else if (advance_i) begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      fidx_q     <= fidx_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      acc_q      <= acc_d;
      mask_q     <= mask_d;
      staged_q   <= staged_d;
      held_q     <= held_d;
    end
  end

  `FDTP_ASSERT(a_all_fields_stop, (fidx_q != 2'd3) || (phase_q == fdtp_pkg::PH_STOP), "three fields parsed but parsing not stopped")
  `FDTP_ASSERT(a_acc_limit, acc_q <= fdtp_pkg::MAG_LIMIT, "digit accumulator above magnitude limit")
  `FDTP_ASSERT_NEXT(a_close_leaves_frame, advance_i && emit_o, !in_frame_q, "frame still open after close byte")
  `FDTP_ASSERT(a_mask_matches_count, $countones(mask_q) == int'(fidx_q), "staged mask disagrees with field count")

endmodule

### sv/fdtp_out_reg.sv
// result register holding one parsed channel triplet until it is taken
// depends on fdtp_pkg
module fdtp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fdtp_pkg::result_t result_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output fdtp_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  fdtp_pkg::result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### sv/framed_decimal_triplet_parser_unit.sv
// top level of the framed decimal triplet parser: config registers and the two stages
// depends on fdtp_pkg, fdtp_in_reg, fdtp_parse_core, fdtp_out_reg, assert_macros.svh
//
// One received byte is taken per clock cycle unless a close byte is held back. A byte is
// captured in the input register, and the parse logic updates frame and field state from
// it when it moves on. A close byte in a frame loads the result register; the result is
// presented in the cycle after its close byte is taken, and a new result can load while
// the waiting one is taken. The input register takes bytes while a result waits and holds
// back only a second close byte then. Frames are delimited by the open and close bytes,
// '<' and '>' after reset, written by the user through the cfg port while idle; not enforced.
`include "assert_macros.svh"

module framed_decimal_triplet_parser_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   rx_valid_i,
  output logic                   rx_ready_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output fdtp_pkg::value_t       chan0_value_o,
  output fdtp_pkg::value_t       chan1_value_o,
  output fdtp_pkg::value_t       chan2_value_o,
  output logic [1:0]             fields_parsed_o
);

  logic [7:0]        open_q;
  logic [7:0]        close_q;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              advance;
  logic              emit;
  logic              out_free;
  fdtp_pkg::result_t core_res;
  fdtp_pkg::result_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= fdtp_pkg::OPEN_RST;
      close_q <= fdtp_pkg::CLOSE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdtp_pkg::CFG_OPEN:  open_q  <= cfg_wdata_i;
        fdtp_pkg::CFG_CLOSE: close_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a byte moves on unless it would produce a result with nowhere to go
  assign advance = s1_valid && (!emit || out_free);

  fdtp_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_valid_i),
    .ready_o (rx_ready_o),
    .byte_i  (rx_byte_i),
    .valid_o (s1_valid),
    .take_i  (advance),
    .byte_o  (s1_byte)
  );

  fdtp_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s1_valid),
    .byte_i       (s1_byte),
    .advance_i    (advance),
    .open_byte_i  (open_q),
    .close_byte_i (close_q),
    .emit_o       (emit),
    .result_o     (core_res)
  );

  fdtp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (core_res),
    .free_o   (out_free),
    .valid_o  (res_valid_o),
    .ready_i  (res_ready_i),
    .result_o (out_res)
  );

  assign chan0_value_o   = out_res.chan[0];
  assign chan1_value_o   = out_res.chan[1];
  assign chan2_value_o   = out_res.chan[2];
  assign fields_parsed_o = out_res.fields;

  `FDTP_ASSERT(a_ready_when_out_free, !out_free || rx_ready_o, "input stalled, result reg free")
  `FDTP_ASSERT_NEXT(a_result_follows_emit, advance && emit, res_valid_o, "close gave no result")
  `FDTP_ASSERT(a_no_load_when_full, !(advance && emit) || out_free, "result register overwritten")

endmodule
